@@ hw/rtl/dsu_pkg.sv @@
// package: shared constants, sequencer states and result type for the union-find core
package dsu_pkg;

    localparam int NODES_DEF  = 1024;
    localparam int NODE_W     = 10;
    localparam int WEIGHT_W   = 31;
    localparam int LMW_W      = 32;
    localparam int RANK_W     = 4;
    localparam int NODE_CMP_W = 17;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 48;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_DECIDE,
        ST_BUMP,
        ST_DONE
    } dsu_state_t;

    typedef struct packed {
        logic [LMW_W-1:0]  last_merge_weight;
        logic [NODE_W-1:0] set_root;
        logic              merged;
    } dsu_result_t;

endpackage

@@ hw/rtl/dsu_mem.sv @@
// single-port-write, single-port-read node store with registered read data
module dsu_mem #(
    parameter int DEPTH = dsu_pkg::NODES_DEF,
    parameter int AW    = $clog2(dsu_pkg::NODES_DEF),
    parameter int DW    = dsu_pkg::RANK_W + $clog2(dsu_pkg::NODES_DEF)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/dsu_ctrl.sv @@
// sequencer: clear sweep, root walks over the shared compare unit, link and rank update
module dsu_ctrl #(
    parameter int NODES = dsu_pkg::NODES_DEF,
    parameter int IDX_W = $clog2(dsu_pkg::NODES_DEF),
    parameter int DW    = dsu_pkg::RANK_W + $clog2(dsu_pkg::NODES_DEF)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [dsu_pkg::NODE_W-1:0]    node_a,
    input  logic [dsu_pkg::NODE_W-1:0]    node_b,
    input  logic [dsu_pkg::WEIGHT_W-1:0]  edge_weight,
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_waddr,
    output logic [DW-1:0]                 mem_wdata,
    output logic [IDX_W-1:0]              mem_raddr,
    input  logic [DW-1:0]                 mem_rdata,
    output logic                          done_valid,
    input  logic                          slot_free,
    output dsu_pkg::dsu_result_t          result
);

    localparam logic [dsu_pkg::NODE_CMP_W-1:0] NODES_L = dsu_pkg::NODE_CMP_W'(NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    dsu_pkg::dsu_state_t state_reg, state_next;

    logic [IDX_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [IDX_W-1:0]             b_idx_reg, b_idx_next;
    logic [IDX_W-1:0]             root_a_reg, root_a_next;
    logic [IDX_W-1:0]             root_b_reg, root_b_next;
    logic [dsu_pkg::RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [dsu_pkg::RANK_W-1:0]   rank_b_reg, rank_b_next;
    logic [dsu_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic [dsu_pkg::LMW_W-1:0]    latest_reg, latest_next;
    logic                         merged_reg, merged_next;
    logic [IDX_W-1:0]             root_reg, root_next;

    logic                         accept;
    logic                         in_range;
    logic [IDX_W-1:0]             a_idx;
    logic [IDX_W-1:0]             rd_parent;
    logic [dsu_pkg::RANK_W-1:0]   rd_rank;
    logic [IDX_W-1:0]             cmp_lhs;
    logic [IDX_W-1:0]             cmp_rhs;
    logic                         cmp_eq;
    logic                         a_wins;
    logic                         bump;

    assign req_ready = (state_reg == dsu_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_range  = (dsu_pkg::NODE_CMP_W'(node_a) < NODES_L)
                    && (dsu_pkg::NODE_CMP_W'(node_b) < NODES_L);
    assign a_idx     = IDX_W'(node_a);
    assign rd_parent = mem_rdata[IDX_W-1:0];
    assign rd_rank   = mem_rdata[DW-1:IDX_W];

    // shared equality unit
    assign cmp_lhs = (state_reg == dsu_pkg::ST_DECIDE) ? root_a_reg : rd_parent;
    assign cmp_rhs = (state_reg == dsu_pkg::ST_DECIDE) ? root_b_reg : cur_reg;
    assign cmp_eq  = (cmp_lhs == cmp_rhs);

    assign a_wins = (rank_a_reg > rank_b_reg);
    assign bump   = (rank_a_reg == rank_b_reg) && (rank_b_reg != dsu_pkg::RANK_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dsu_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            latest_reg  <= '1;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            latest_reg  <= latest_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        b_idx_reg  <= b_idx_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        w_reg      <= w_next;
        merged_reg <= merged_next;
        root_reg   <= root_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsu_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            dsu_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = in_range ? dsu_pkg::ST_WALK_A : dsu_pkg::ST_DONE;
                end
            end
            dsu_pkg::ST_WALK_A: begin
                if (cmp_eq) begin
                    state_next = dsu_pkg::ST_WALK_B;
                end
            end
            dsu_pkg::ST_WALK_B: begin
                if (cmp_eq) begin
                    state_next = dsu_pkg::ST_DECIDE;
                end
            end
            dsu_pkg::ST_DECIDE: begin
                if (!cmp_eq && !a_wins && bump) begin
                    state_next = dsu_pkg::ST_BUMP;
                end else begin
                    state_next = dsu_pkg::ST_DONE;
                end
            end
            dsu_pkg::ST_BUMP: begin
                state_next = dsu_pkg::ST_DONE;
            end
            dsu_pkg::ST_DONE: begin
                if (slot_free) begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dsu_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        b_idx_next   = b_idx_reg;
        root_a_next  = root_a_reg;
        root_b_next  = root_b_reg;
        rank_a_next  = rank_a_reg;
        rank_b_next  = rank_b_reg;
        w_next       = w_reg;
        latest_next  = latest_reg;
        merged_next  = merged_reg;
        root_next    = root_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_cnt_reg;
        mem_wdata    = {{dsu_pkg::RANK_W{1'b0}}, clr_cnt_reg};
        mem_raddr    = cur_reg;
        unique case (state_reg)
            dsu_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            dsu_pkg::ST_IDLE: begin
                mem_raddr = a_idx;
                if (accept) begin
                    cur_next    = a_idx;
                    b_idx_next  = IDX_W'(node_b);
                    w_next      = edge_weight;
                    merged_next = 1'b0;
                    root_next   = '0;
                end
            end
            dsu_pkg::ST_WALK_A: begin
                if (cmp_eq) begin
                    root_a_next = cur_reg;
                    rank_a_next = rd_rank;
                    mem_raddr   = b_idx_reg;
                    cur_next    = b_idx_reg;
                end else begin
                    mem_raddr = rd_parent;
                    cur_next  = rd_parent;
                end
            end
            dsu_pkg::ST_WALK_B: begin
                mem_raddr = rd_parent;
                if (cmp_eq) begin
                    root_b_next = cur_reg;
                    rank_b_next = rd_rank;
                end else begin
                    cur_next = rd_parent;
                end
            end
            dsu_pkg::ST_DECIDE: begin
                if (cmp_eq) begin
                    merged_next = 1'b0;
                    root_next   = root_a_reg;
                end else begin
                    merged_next = 1'b1;
                    latest_next = {1'b0, w_reg};
                    mem_we      = 1'b1;
                    if (a_wins) begin
                        mem_waddr = root_b_reg;
                        mem_wdata = {rank_b_reg, root_a_reg};
                        root_next = root_a_reg;
                    end else begin
                        mem_waddr = root_a_reg;
                        mem_wdata = {rank_a_reg, root_b_reg};
                        root_next = root_b_reg;
                    end
                end
            end
            dsu_pkg::ST_BUMP: begin
                mem_we    = 1'b1;
                mem_waddr = root_b_reg;
                mem_wdata = {rank_b_reg + dsu_pkg::RANK_W'(1), root_b_reg};
            end
            dsu_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign done_valid               = (state_reg == dsu_pkg::ST_DONE);
    assign result.merged            = merged_reg;
    assign result.set_root          = dsu_pkg::NODE_W'(root_reg);
    assign result.last_merge_weight = latest_reg;

endmodule

@@ hw/rtl/disjoint_set_union_by_rank_core.sv @@
// top level: union-by-rank disjoint-set engine with stream ports and output register
//
//  channel  | direction | tdata fields (low bit up)                      | width
//  s_       | in        | node_a[9:0], node_b[19:10], edge_weight[50:20] | 56
//  m_       | out       | merged[0], set_root[10:1], last_merge_weight[42:11] | 48
//
// an edge walks from node_a up to its root, then from node_b up to its root, then links
// the roots, plus a rank update when a rank grows; depths are bounded by log2(NODES)
// the walks follow one parent link at a time through the single read port of the node store
// after reset a clearing pass over all NODES entries restores identity parents and zero ranks
// a result waits in the output register while the next request is taken
module disjoint_set_union_by_rank_core #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dsu_pkg::S_DATA_W-1:0]   s_tdata,  // node_a, node_b, edge_weight
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dsu_pkg::M_DATA_W-1:0]   m_tdata   // merged, set_root, last_merge_weight
);

    localparam int IDX_W = $clog2(NODES);
    localparam int DW    = dsu_pkg::RANK_W + IDX_W;
    localparam int PAD_W = dsu_pkg::M_DATA_W - $bits(dsu_pkg::dsu_result_t);

    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [DW-1:0]                 mem_wdata;
    logic [IDX_W-1:0]              mem_raddr;
    logic [DW-1:0]                 mem_rdata;
    logic                          done_valid;
    logic                          slot_free;
    dsu_pkg::dsu_result_t          result;
    logic                          out_valid_reg, out_valid_next;
    dsu_pkg::dsu_result_t          out_data_reg, out_data_next;

    dsu_ctrl #(
        .NODES (NODES),
        .IDX_W (IDX_W),
        .DW    (DW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .node_a      (s_tdata[dsu_pkg::NODE_W-1:0]),
        .node_b      (s_tdata[2*dsu_pkg::NODE_W-1:dsu_pkg::NODE_W]),
        .edge_weight (s_tdata[2*dsu_pkg::NODE_W+dsu_pkg::WEIGHT_W-1:2*dsu_pkg::NODE_W]),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .done_valid  (done_valid),
        .slot_free   (slot_free),
        .result      (result)
    );

    dsu_mem #(
        .DEPTH (NODES),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (slot_free) begin
            out_valid_next = done_valid;
            if (done_valid) begin
                out_data_next = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg};

endmodule

@@ hw/rtl/dsu_checker.sv @@
// port-level checker for the union-find core and its bind
module dsu_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [dsu_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dsu_pkg::M_DATA_W-1:0] m_tdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a merge always carries a real, non-negative weight
    a_merge_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[42])
        else $error("merge reported without a recorded weight");

    // reset starts the clearing pass with nothing pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("activity right after reset");

endmodule

bind disjoint_set_union_by_rank_core dsu_checker u_dsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/testbench.sv @@
// testbench for the union-by-rank disjoint-set core: directed, deep-tree and random edge tests
module testbench;

    localparam int NODE_COUNT     = dsu_pkg::NODES_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [dsu_pkg::S_DATA_W-1:0] s_tdata  = '0;  // node_a, node_b, edge_weight
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [dsu_pkg::M_DATA_W-1:0] m_tdata;        // merged, set_root, last_merge_weight

    disjoint_set_union_by_rank_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // mirror of the node store
    logic [dsu_pkg::NODE_W-1:0] parent_of [NODE_COUNT];
    logic [dsu_pkg::RANK_W-1:0] rank_of   [NODE_COUNT];
    logic [dsu_pkg::LMW_W-1:0]  merge_weight;

    dsu_pkg::dsu_result_t pending_results[$];
    int                   error_count = 0;
    int                   idle_cycles = 0;
    bit                   tx_calm     = 1'b0;
    bit                   rx_calm     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [dsu_pkg::NODE_W-1:0] find_root(
        input logic [dsu_pkg::NODE_W-1:0] start
    );
        logic [dsu_pkg::NODE_W-1:0] cur;
        int                         hops;
        cur  = start;
        hops = 0;
        while (hops < NODE_COUNT && parent_of[cur] != cur) begin
            cur = parent_of[cur];
            hops++;
        end
        return cur;
    endfunction

    function automatic dsu_pkg::dsu_result_t join_sets(
        input logic [dsu_pkg::NODE_W-1:0]   node_a,
        input logic [dsu_pkg::NODE_W-1:0]   node_b,
        input logic [dsu_pkg::WEIGHT_W-1:0] weight
    );
        dsu_pkg::dsu_result_t       res;
        logic [dsu_pkg::NODE_W-1:0] root_a;
        logic [dsu_pkg::NODE_W-1:0] root_b;
        res.merged   = 1'b0;
        res.set_root = '0;
        if (node_a < NODE_COUNT && node_b < NODE_COUNT) begin
            root_a = find_root(node_a);
            root_b = find_root(node_b);
            if (root_a == root_b) begin
                res.set_root = root_a;
            end else begin
                res.merged = 1'b1;
                if (rank_of[root_a] > rank_of[root_b]) begin
                    parent_of[root_b] = root_a;
                    res.set_root      = root_a;
                end else begin
                    parent_of[root_a] = root_b;
                    if (rank_of[root_a] == rank_of[root_b] && rank_of[root_b] != dsu_pkg::RANK_MAX)
                        rank_of[root_b] = rank_of[root_b] + dsu_pkg::RANK_W'(1);
                    res.set_root = root_b;
                end
                merge_weight = {1'b0, weight};
            end
        end
        res.last_merge_weight = merge_weight;
        return res;
    endfunction

    task automatic send_edge(
        input logic [dsu_pkg::NODE_W-1:0]   node_a,
        input logic [dsu_pkg::NODE_W-1:0]   node_b,
        input logic [dsu_pkg::WEIGHT_W-1:0] weight
    );
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(dsu_pkg::S_DATA_W - 51){1'b0}}, weight, node_b, node_a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.insert(pending_results.size(), join_sets(node_a, node_b, weight));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [dsu_pkg::WEIGHT_W-1:0] rand_weight();
        return dsu_pkg::WEIGHT_W'($urandom());
    endfunction

    task automatic test_directed();
        int step;
        int base;
        tx_calm = 1'b0;
        send_edge(10'd0, 10'd1023, 31'h7FFF_FFFF);
        send_edge(10'd1023, 10'd0, 31'h0000_0001);
        send_edge(10'd5, 10'd5, 31'h2AAA_AAAA);
        send_edge(10'd1023, 10'd1023, 31'h5555_5555);
        // full binomial tree over 16..31, ties everywhere
        for (step = 1; step < 16; step = step * 2) begin
            for (base = 16; base < 32; base += 2 * step)
                send_edge(dsu_pkg::NODE_W'(base), dsu_pkg::NODE_W'(base + step),
                          (step == 4) ? 31'd0 : rand_weight());
        end
        send_edge(10'd16, 10'd31, 31'h5555_5555);
        send_edge(10'd31, 10'd16, 31'h2AAA_AAAA);
        // higher rank on either side
        send_edge(10'd16, 10'd40, 31'h7FFF_FFFE);
        send_edge(10'd41, 10'd16, 31'h0000_0002);
        wait_drained();
    endtask

    task automatic test_deep_trees();
        int                         step;
        int                         base;
        logic [dsu_pkg::NODE_W-1:0] pick_a;
        logic [dsu_pkg::NODE_W-1:0] pick_b;
        for (step = 1; step < 256; step = step * 2) begin
            tx_calm = ($urandom_range(0, 2) == 0);
            for (base = 512; base < 768; base += 2 * step) begin
                pick_a = dsu_pkg::NODE_W'(base + $urandom_range(0, step - 1));
                pick_b = dsu_pkg::NODE_W'(base + step + $urandom_range(0, step - 1));
                if ($urandom_range(0, 1))
                    send_edge(pick_a, pick_b, rand_weight());
                else
                    send_edge(pick_b, pick_a, rand_weight());
            end
        end
        // deep walks on a finished tree
        repeat (6) send_edge(dsu_pkg::NODE_W'(512 + $urandom_range(0, 255)),
                             dsu_pkg::NODE_W'(512 + $urandom_range(0, 255)),
                             rand_weight());
        // hold off until the core has emptied
        wait_drained();
    endtask

    task automatic test_random_windows(input int edge_total);
        int sent;
        int span;
        int base;
        int burst;
        int pick;
        int k;
        sent = 0;
        while (sent < edge_total) begin
            span    = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 512)
                                                  : $urandom_range(4, 48);
            base    = $urandom_range(0, NODE_COUNT - span);
            burst   = $urandom_range(8, 40);
            tx_calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < burst; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: send_edge(dsu_pkg::NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                                    dsu_pkg::NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                                    rand_weight());
                    2: begin
                        pick = $urandom_range(0, span - 1);
                        send_edge(dsu_pkg::NODE_W'(base + pick), dsu_pkg::NODE_W'(base + pick),
                                  rand_weight());
                    end
                    default: send_edge(dsu_pkg::NODE_W'(base + $urandom_range(0, span - 1)),
                                       dsu_pkg::NODE_W'(base + $urandom_range(0, span - 1)),
                                       rand_weight());
                endcase
            end
            sent += burst;
        end
    endtask

    // result side stalls
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        end
    end

    always @(posedge aclk) begin
        dsu_pkg::dsu_result_t got;
        dsu_pkg::dsu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(dsu_pkg::dsu_result_t)-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result expected none got %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.merged !== want.merged) begin
                    $display("%0t merged expected %0b got %0b", $time, want.merged, got.merged);
                    error_count++;
                end
                if (got.set_root !== want.set_root) begin
                    $display("%0t set_root expected %0d got %0d",
                             $time, want.set_root, got.set_root);
                    error_count++;
                end
                if (got.last_merge_weight !== want.last_merge_weight) begin
                    $display("%0t last_merge_weight expected %h got %h",
                             $time, want.last_merge_weight, got.last_merge_weight);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < NODE_COUNT; i++) begin
            parent_of[i] = dsu_pkg::NODE_W'(i);
            rank_of[i]   = '0;
        end
        merge_weight = '1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_deep_trees();
        test_random_windows(620);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ disjoint_set_union_by_rank_core.f @@
hw/rtl/dsu_pkg.sv
hw/rtl/dsu_mem.sv
hw/rtl/dsu_ctrl.sv
hw/rtl/disjoint_set_union_by_rank_core.sv
hw/rtl/dsu_checker.sv
tb/testbench.sv
